@@ design/ring_buffer_deque_assert.svh @@
// Assertion macros used by the deque top-level RTL (ring_buffer_deque).
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef RING_BUFFER_DEQUE_ASSERT_SVH
`define RING_BUFFER_DEQUE_ASSERT_SVH

// Checks that a property holds at every clock edge.
`define RBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rbd_pkg.sv @@
`default_nettype none
package rbd_pkg;

	// Ring geometry. DEPTH must stay a power of two so that positions wrap by truncation.
	localparam int DEPTH  = 32;
	localparam int ELEM_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = 5;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ       = 3'd4,
		OP_WRITE      = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Request beat.
	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  index;
		logic [ELEM_W-1:0] value;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic [ELEM_W-1:0] data;
		status_t           status;
		logic [CNT_W-1:0]  count;
	} rsp_t;

	// Access issued to the ring store.
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [ELEM_W-1:0] wdata;
	} mem_cmd_t;

	// Response fields known when the request is accepted.
	typedef struct packed {
		logic             rd;
		status_t          status;
		logic [CNT_W-1:0] count;
	} meta_t;

endpackage
`default_nettype wire

@@ design/ring_buffer_deque.sv @@
// Path: an accepted request beat goes through the read stage and then the output register to rsp_valid.
// Throughput: one request per cycle while req_stall is low; head and count update at acceptance and the
// single-port ring store takes at most one access per request.
// Reset: arst_n clears head, count and all valid flags; store contents are undefined
// until written, and there is no clearing pass.
`default_nettype none
module ring_buffer_deque (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire rbd_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rbd_pkg::rsp_t      rsp
);
	import rbd_pkg::*;

	`include "ring_buffer_deque_assert.svh"

	logic              accept;
	logic              adv;
	mem_cmd_t          cmd;
	meta_t             meta;
	logic [ELEM_W-1:0] rdata;
	logic              valid_s1;
	meta_t             meta_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// The read stage moves on when the output register is empty or being taken.
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	rbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.cmd    (cmd),
		.meta   (meta)
	);

	rbd_ram #(
		.DEPTH (DEPTH),
		.WIDTH (ELEM_W)
	) u_ram (
		.clk   (clk),
		.en    (cmd.en),
		.we    (cmd.we),
		.addr  (cmd.addr),
		.wdata (cmd.wdata),
		.rdata (rdata)
	);

	// Read stage: waits for the store's registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// Output register holds the response beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rsp_q.data   <= meta_s1.rd ? rdata : '0;
			rsp_q.status <= meta_s1.status;
			rsp_q.count  <= meta_s1.count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RBD_ASSERT(a_stall_needs_s1, req_stall |-> valid_s1, "stall raised with empty read stage")
	`RBD_ASSERT_NEXT(a_accept_fills_s1, accept, valid_s1, "accepted beat lost before read stage")
	`RBD_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv, valid_s1 && $stable(meta_s1) && (!meta_s1.rd || $stable(rdata)), "read stage changed while blocked")
	`RBD_ASSERT(a_refused_zero, rsp_valid_q && rsp_q.status != ST_OK |-> rsp_q.data == '0, "refused request returned data")
	`RBD_ASSERT(a_count_bound, rsp_valid_q |-> rsp_q.count <= CNT_W'(DEPTH), "count beyond capacity")

endmodule
`default_nettype wire

@@ design/rbd_ram.sv @@
`default_nettype none
module rbd_ram #(
	parameter int DEPTH  = 32,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port, registered read; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ design/rbd_ctrl.sv @@
`default_nettype none
module rbd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire rbd_pkg::req_t    req,
	output rbd_pkg::mem_cmd_t     cmd,
	output rbd_pkg::meta_t        meta
);
	import rbd_pkg::*;

	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] head_d;
	logic [CNT_W-1:0]  count_d;
	logic              full;
	logic              empty;
	logic              in_range;
	logic              access;
	logic              wr;
	logic              rd;
	status_t           status;
	logic [ADDR_W-1:0] addr;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign in_range = (CNT_W'(req.index) < count_q);

	// Decode the request against the current head and count.
	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		status  = ST_OK;
		access  = 1'b0;
		wr      = 1'b0;
		rd      = 1'b0;
		addr    = head_q;
		case (req.op)
			OP_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					access  = 1'b1;
					wr      = 1'b1;
					addr    = head_q + count_q[ADDR_W-1:0];
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					access  = 1'b1;
					wr      = 1'b1;
					addr    = head_q - ADDR_W'(1);
					head_d  = head_q - ADDR_W'(1);
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					access  = 1'b1;
					rd      = 1'b1;
					addr    = head_q + count_q[ADDR_W-1:0] - ADDR_W'(1);
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					access  = 1'b1;
					rd      = 1'b1;
					addr    = head_q;
					head_d  = head_q + ADDR_W'(1);
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					access = 1'b1;
					rd     = 1'b1;
					addr   = head_q + ADDR_W'(req.index);
				end
			end
			OP_WRITE: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					access = 1'b1;
					wr     = 1'b1;
					addr   = head_q + ADDR_W'(req.index);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// Store access goes out only for an accepted beat.
	always_comb begin
		cmd.en      = access && accept;
		cmd.we      = wr;
		cmd.addr    = addr;
		cmd.wdata   = req.value;
		meta.rd     = rd;
		meta.status = status;
		meta.count  = count_d;
	end

	// Head and count move at acceptance, so the next beat sees them at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

endmodule
`default_nettype wire
